/* sv/prlf_pkg.sv */
// package for the page replacement block: frame geometry, derived widths,
// policy codes. no dependencies.
`default_nettype none
package prlf_pkg;

	localparam int FRAMES      = 4;
	localparam int PAGE_WIDTH  = 16;
	localparam int FRAME_IDX_W = 4;
	localparam int COUNT_W     = 32;

	localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int AGE_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FILL_W = $clog2(FRAMES + 1);

	localparam logic [AGE_W-1:0]  YOUNGEST  = AGE_W'(FRAMES - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAMES);

	typedef enum logic {
		POL_LRU  = 1'b0,
		POL_FIFO = 1'b1
	} policy_t;

	typedef logic [PAGE_WIDTH-1:0] page_t;
	typedef logic [AGE_W-1:0]      age_t;

endpackage
`default_nettype wire

/* sv/page_replacement_lru_fifo.sv */
// page frame replacement block, lru or fifo, top level.
// depends on prlf_pkg.
//
// Each word on the input channel is one page access; exactly one result word
// comes back per access, in order. The block takes one word per clock while
// in_stall is low; a stalled output holds it off. The access sits in an input
// register, then a parallel compare against all frames, victim search and age
// update writes both the frame registers and the result register. Because
// every frame is compared and re-aged in that same step, the next access always
// sees the updated frames. The policy register (0 lru, 1 fifo) should be written
// only while no access is in flight; it applies from the next access.
`default_nettype none
module page_replacement_lru_fifo
	import prlf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_wdata,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [PAGE_WIDTH-1:0]  page_number,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        hit,
	output logic [FRAME_IDX_W-1:0]      frame_index,
	output logic                        evicted_valid,
	output logic [PAGE_WIDTH-1:0]       evicted_page,
	output logic [COUNT_W-1:0]          hit_count
);

	policy_t              policy_q;
	page_t                page_q  [FRAMES];
	logic [FRAMES-1:0]    fvalid_q;
	age_t                 age_q   [FRAMES];
	logic [FILL_W-1:0]    fill_q;
	logic [COUNT_W-1:0]   hits_q;

	logic                 valid_s1;
	page_t                page_s1;

	logic                 valid_s2;
	logic                 hit_s2;
	logic [SLOT_W-1:0]    slot_s2;
	logic                 ev_valid_s2;
	page_t                ev_page_s2;
	logic [COUNT_W-1:0]   count_s2;

	logic                 advance;
	logic                 accept;

	logic                 hit_c;
	logic [SLOT_W-1:0]    hit_slot_c;
	logic [SLOT_W-1:0]    victim_c;
	age_t                 best_age_c;
	logic                 full_c;
	logic [SLOT_W-1:0]    slot_c;
	age_t                 floor_c;
	logic                 reage_c;
	logic [COUNT_W-1:0]   count_c;
	age_t                 age_n   [FRAMES];

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// frame lookup
	always_comb begin
		hit_c      = 1'b0;
		hit_slot_c = '0;
		for (int f = 0; f < FRAMES; f++) begin
			if (!hit_c && fvalid_q[f] && page_q[f] == page_s1) begin
				hit_c      = 1'b1;
				hit_slot_c = SLOT_W'(f);
			end
		end
	end

	// oldest frame, lowest index on a tie
	always_comb begin
		victim_c   = '0;
		best_age_c = age_q[0];
		for (int f = 1; f < FRAMES; f++) begin
			if (age_q[f] < best_age_c) begin
				best_age_c = age_q[f];
				victim_c   = SLOT_W'(f);
			end
		end
	end

	assign full_c  = (fill_q == FILL_FULL);
	assign slot_c  = hit_c ? hit_slot_c : (full_c ? victim_c : fill_q[SLOT_W-1:0]);
	assign floor_c = hit_c ? age_q[hit_slot_c] : '0;
	assign reage_c = !hit_c || (policy_q == POL_LRU);
	assign count_c = (hit_c && hits_q != '1) ? hits_q + COUNT_W'(1) : hits_q;

	always_comb begin
		for (int f = 0; f < FRAMES; f++) begin
			age_n[f] = age_q[f];
			if (reage_c) begin
				if (SLOT_W'(f) == slot_c) begin
					age_n[f] = YOUNGEST;
				end else if (fvalid_q[f] && age_q[f] > floor_c) begin
					age_n[f] = age_q[f] - AGE_W'(1);
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_LRU;
			fvalid_q <= '0;
			fill_q   <= '0;
			hits_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int f = 0; f < FRAMES; f++) begin
				age_q[f] <= '0;
			end
		end else begin
			if (cfg_we) begin
				policy_q <= policy_t'(cfg_wdata);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				hits_q <= count_c;
				for (int f = 0; f < FRAMES; f++) begin
					age_q[f] <= age_n[f];
				end
				if (!hit_c) begin
					fvalid_q[slot_c] <= 1'b1;
					if (!full_c) begin
						fill_q <= fill_q + FILL_W'(1);
					end
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1 <= page_number;
		end
		if (advance) begin
			if (!hit_c) begin
				page_q[slot_c] <= page_s1;
			end
			hit_s2      <= hit_c;
			slot_s2     <= slot_c;
			ev_valid_s2 <= !hit_c && full_c;
			ev_page_s2  <= (!hit_c && full_c) ? page_q[victim_c] : '0;
			count_s2    <= count_c;
		end
	end

	assign out_valid     = valid_s2;
	assign hit           = hit_s2;
	assign frame_index   = FRAME_IDX_W'(slot_s2);
	assign evicted_valid = ev_valid_s2;
	assign evicted_page  = ev_page_s2;
	assign hit_count     = count_s2;

endmodule
`default_nettype wire

/* sv/prlf_checker.sv */
// port-level checks for the page replacement block, bound to the top level.
// depends on prlf_pkg and page_replacement_lru_fifo.
`default_nettype none
module prlf_checker
	import prlf_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic                   hit,
	input wire logic [FRAME_IDX_W-1:0] frame_index,
	input wire logic                   evicted_valid,
	input wire logic [PAGE_WIDTH-1:0]  evicted_page,
	input wire logic [COUNT_W-1:0]     hit_count
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(frame_index)
			&& $stable(evicted_page) && $stable(hit_count))
		else $error("stalled result word changed");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted_valid)
		else $error("eviction reported on a hit");

	// no eviction means zero evicted page
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_page == '0)
		else $error("evicted page nonzero without eviction");

	// a hit word always counts itself
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> hit_count != '0)
		else $error("hit word with zero hit count");

	// frame index stays within the frame set
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_index < FRAME_IDX_W'(FRAMES))
		else $error("frame index out of range");

endmodule

bind page_replacement_lru_fifo prlf_checker u_prlf_checker (.*);
`default_nettype wire

/* tb/sv/page_replacement_lru_fifo_test.sv */
// self-checking testbench for page_replacement_lru_fifo: directed access table,
// then random page streams under both policies, checked against a frame model.
// depends on prlf_pkg and the page_replacement_lru_fifo rtl.
`default_nettype none
module page_replacement_lru_fifo_test;
	import prlf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 200;
	localparam int LONG_HOLD = 120;
	localparam int SETTLE_CYCLES = 4;
	localparam int DIRECTED_ROWS = 19;

	typedef struct packed {
		logic                   hit;
		logic [FRAME_IDX_W-1:0] frame;
		logic                   ev_valid;
		page_t                  ev_page;
		logic [COUNT_W-1:0]     hits;
	} access_result_t;

	typedef struct packed {
		policy_t        pol;
		page_t          page;
		logic           typed;
		access_result_t res;
	} access_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	page_t page_number = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic hit;
	logic [FRAME_IDX_W-1:0] frame_index;
	logic evicted_valid;
	page_t evicted_page;
	logic [COUNT_W-1:0] hit_count;

	// frame model
	page_t              mdl_page [FRAMES];
	logic               mdl_valid [FRAMES];
	age_t               mdl_age [FRAMES];
	int unsigned        mdl_fill = 0;
	logic [COUNT_W-1:0] mdl_hits = '0;
	policy_t            mdl_policy = POL_LRU;

	access_result_t pending_results [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	logic send_idle = 1'b1;
	logic recv_idle = 1'b1;
	logic hold_pending = 1'b0;

	access_row_t directed_accesses [DIRECTED_ROWS] = '{
		'{POL_LRU,  16'h0000, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd0}},
		'{POL_LRU,  16'hFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd0}},
		'{POL_LRU,  16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd1}},
		'{POL_LRU,  16'h8001, 1'b1, '{1'b0, 4'd2, 1'b0, 16'h0000, 32'd1}},
		'{POL_LRU,  16'h7FFE, 1'b1, '{1'b0, 4'd3, 1'b0, 16'h0000, 32'd1}},
		'{POL_LRU,  16'h1234, 1'b1, '{1'b0, 4'd1, 1'b1, 16'hFFFF, 32'd1}},
		'{POL_LRU,  16'h0000, 1'b0, '0},
		'{POL_LRU,  16'hFFFF, 1'b0, '0},
		'{POL_LRU,  16'h8001, 1'b0, '0},
		'{POL_LRU,  16'h1234, 1'b0, '0},
		'{POL_LRU,  16'hAAAA, 1'b0, '0},
		'{POL_LRU,  16'h5555, 1'b0, '0},
		'{POL_FIFO, 16'h5555, 1'b0, '0},
		'{POL_FIFO, 16'hAAAA, 1'b0, '0},
		'{POL_FIFO, 16'h0F0F, 1'b0, '0},
		'{POL_FIFO, 16'hF0F0, 1'b0, '0},
		'{POL_FIFO, 16'h0F0F, 1'b0, '0},
		'{POL_FIFO, 16'h0001, 1'b0, '0},
		'{POL_FIFO, 16'h0002, 1'b0, '0}
	};

	page_replacement_lru_fifo DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.page_number   (page_number),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.hit_count     (hit_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int f = 0; f < FRAMES; f++) begin
			mdl_page[f] = '0;
			mdl_valid[f] = 1'b0;
			mdl_age[f] = '0;
		end
	end

	// frame t becomes youngest, valid frames above floor_age age by one
	function automatic void make_frame_youngest(int t, age_t floor_age);
		for (int f = 0; f < FRAMES; f++) begin
			if (f != t && mdl_valid[f] && mdl_age[f] > floor_age)
				mdl_age[f] = mdl_age[f] - 1'b1;
		end
		mdl_age[t] = YOUNGEST;
	endfunction

	function automatic access_result_t predict_access(page_t pg);
		access_result_t r;
		int slot;
		int best;
		logic found;
		r = '0;
		slot = 0;
		found = 1'b0;
		for (int f = 0; f < FRAMES; f++) begin
			if (!found && mdl_valid[f] && mdl_page[f] == pg) begin
				found = 1'b1;
				slot = f;
			end
		end
		if (found) begin
			r.hit = 1'b1;
			if (mdl_hits != '1)
				mdl_hits = mdl_hits + 1'b1;
			if (mdl_policy == POL_LRU)
				make_frame_youngest(slot, mdl_age[slot]);
		end else if (mdl_fill < FRAMES) begin
			slot = mdl_fill;
			mdl_page[slot] = pg;
			mdl_valid[slot] = 1'b1;
			make_frame_youngest(slot, '0);
			mdl_fill++;
		end else begin
			best = FRAMES;
			for (int f = 0; f < FRAMES; f++) begin
				if (mdl_valid[f] && int'(mdl_age[f]) < best) begin
					best = mdl_age[f];
					slot = f;
				end
			end
			r.ev_valid = 1'b1;
			r.ev_page = mdl_page[slot];
			mdl_page[slot] = pg;
			make_frame_youngest(slot, '0);
		end
		r.frame = FRAME_IDX_W'(slot);
		r.hits = mdl_hits;
		return r;
	endfunction

	task automatic send_access(page_t pg, logic typed, access_result_t typed_res);
		int gap;
		access_result_t predicted;
		gap = send_idle ? $urandom_range(0, 14) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		page_number <= pg;
		do @(posedge clk); while (!(in_valid && !in_stall));
		predicted = predict_access(pg);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_policy(policy_t pol);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= pol;
		@(negedge clk);
		cfg_we <= 1'b0;
		mdl_policy = pol;
	endtask

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// result word checker
	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("hit", 32'(want.hit), 32'(hit));
				compare_field("frame_index", 32'(want.frame), 32'(frame_index));
				compare_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid));
				compare_field("evicted_page", 32'(want.ev_page), 32'(evicted_page));
				compare_field("hit_count", want.hits, hit_count);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// output side stalls, with one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = recv_idle ? $urandom_range(0, 14) : 0;
			if (hold_pending) begin
				hold_pending = 1'b0;
				gap = LONG_HOLD;
			end
			repeat (gap) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin
		page_t pool [8];
		int pool_n;
		page_t pg;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_policy(POL_LRU);
		foreach (directed_accesses[i]) begin
			if (directed_accesses[i].pol != mdl_policy)
				write_policy(directed_accesses[i].pol);
			send_access(directed_accesses[i].page, directed_accesses[i].typed,
				directed_accesses[i].res);
		end
		for (int p = 0; p < PHASES; p++) begin
			write_policy(p[0] ? POL_FIFO : POL_LRU);
			{send_idle, recv_idle} = (p % 4 == 3) ? 2'b00 : ~2'(p % 4);
			if (p == 1)
				hold_pending = 1'b1;
			pool_n = $urandom_range(3, 8);
			for (int k = 0; k < pool_n; k++)
				pool[k] = page_t'($urandom);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if ($urandom_range(0, 9) < 8)
					pg = pool[$urandom_range(0, pool_n - 1)];
				else
					pg = page_t'($urandom);
				send_access(pg, 1'b0, '0);
			end
		end
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
sv/prlf_pkg.sv
sv/page_replacement_lru_fifo.sv
sv/prlf_checker.sv
tb/sv/page_replacement_lru_fifo_test.sv
